FILE: rtl/fua_pkg.sv
// Shared definitions for the federated update aggregator.
// Holds widths, mode codes, beat payload types, controller/datapath structs, helpers.
// Depends on nothing; every other file in rtl/ uses it by scoped name.
package fua_pkg;

    localparam int WIDTH       = 32;
    localparam int MAX_CLIENTS = 1024;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int DCNT_W      = $clog2(WIDTH + 1);

    localparam logic [1:0] MODE_PLAIN    = 2'd0;
    localparam logic [1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [1:0] MODE_QFED     = 2'd2;

    typedef struct packed {
        logic signed [31:0] update_value;
        logic        [31:0] weight_value;
        logic signed [31:0] global_value;
        logic               last_client;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] aggregated_value;
        logic               divide_by_zero;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_final;
        logic accum;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_weighted;
        logic item_last;
        logic div_done;
        logic out_busy;
    } t_status;

    function automatic logic [WIDTH-1:0] sext_to_w(input logic [31:0] v);
        logic [63:0] t;
        t = {{32{v[31]}}, v};
        return t[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] zext_to_w(input logic [31:0] v);
        logic [63:0] t;
        t = {32'd0, v};
        return t[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] cnt_to_w(input logic [CNT_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[WIDTH-1:0];
    endfunction

    function automatic logic [31:0] w_to_32(input logic [WIDTH-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

endpackage

FILE: rtl/federated_update_aggregator.sv
// Federated averaging of one model element: client beats are folded into running sums
// and the beat with last_client set yields the new global element. One item is in work at
// a time. A non-closing item is accumulated directly in plain and q-fed mode; in weighted
// mode it first waits for the radix-2 divider, which yields one quotient bit per cycle.
// A closing item in plain or q-fed mode adds the final division. The result sits in an
// output register, so the next beat is accepted while it waits; a closing item only
// stalls if the previous result is still untaken when its own result is ready. The mode
// register is written through its own channel, which is always ready, and must only be
// written while the block is idle.
// Depends on fua_pkg, fua_ctrl, fua_datapath and fua_divider.
module federated_update_aggregator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fua_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fua_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data
);

    fua_pkg::t_cmd    w_cmd;
    fua_pkg::t_status w_status;

    fua_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fua_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: rtl/fua_divider.sv
// Radix-2 restoring divider with sign-and-magnitude handling for the aggregator.
// One quotient bit per cycle; a zero divisor skips the iterations and yields an all-ones magnitude.
// Depends on fua_pkg.
module fua_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fua_pkg::WIDTH-1:0] i_dividend,
    input  logic [fua_pkg::WIDTH-1:0] i_divisor,
    output logic                      o_done,
    output logic                      o_zero,
    output logic [fua_pkg::WIDTH-1:0] o_quotient
);

    localparam int W = fua_pkg::WIDTH;

    logic                       r_busy, n_busy;
    logic [fua_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]               r_rem, n_rem;
    logic [W-1:0]               r_quo, n_quo;
    logic [W-1:0]               r_div, n_div;
    logic                       r_neg, n_neg;
    logic                       r_zero, n_zero;

    logic [W:0] w_shift;
    logic [W:0] w_diff;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_dividend[W-1];
            n_div  = i_divisor;
            n_rem  = '0;
            n_zero = (i_divisor == '0);
            if (i_divisor == '0) begin
                n_cnt = '0;
                n_quo = '1;
            end else begin
                n_cnt = fua_pkg::DCNT_W'(W);
                n_quo = i_dividend[W-1] ? ('0 - i_dividend) : i_dividend;
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                if (!w_diff[W]) begin
                    n_rem = w_diff[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b0};
                end
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    // The result stays valid after done until the next start.
    assign o_done     = r_busy && (r_cnt == '0);
    assign o_zero     = r_zero;
    assign o_quotient = r_neg ? ('0 - r_quo) : r_quo;

endmodule

FILE: rtl/fua_datapath.sv
// Datapath of the aggregator: mode register, item latch, running sums, output register.
// Owns the shared divider and acts on commands from fua_ctrl.
// Depends on fua_pkg and fua_divider.
module fua_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fua_pkg::t_cmd     i_cmd,
    output fua_pkg::t_status  o_status,
    input  fua_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fua_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data
);

    localparam int W = fua_pkg::WIDTH;

    logic [1:0]                r_mode;
    logic [1:0]                r_item_mode;
    logic [W-1:0]              r_upd;
    logic [W-1:0]              r_wgt;
    logic [W-1:0]              r_glob;
    logic                      r_last;
    logic [W-1:0]              r_value_sum;
    logic [W-1:0]              r_weight_sum;
    logic [fua_pkg::CNT_W-1:0] r_count;
    logic                      r_zero_seen;
    logic                      r_out_valid;
    fua_pkg::t_out_item        r_out;

    logic         w_item_weighted;
    logic         w_item_qfed;
    logic [W-1:0] w_div_a;
    logic [W-1:0] w_div_b;
    logic         w_div_done;
    logic         w_div_zero;
    logic [W-1:0] w_div_q;
    logic [W-1:0] w_result;
    logic         w_flag;

    assign w_item_weighted = (r_item_mode == fua_pkg::MODE_WEIGHTED);
    assign w_item_qfed     = (r_item_mode == fua_pkg::MODE_QFED);

    // Item divisions take operands straight from the accepted beat.
    always_comb begin
        if (i_cmd.div_final) begin
            w_div_a = r_value_sum;
            w_div_b = w_item_qfed ? r_weight_sum : fua_pkg::cnt_to_w(r_count);
        end else begin
            w_div_a = fua_pkg::sext_to_w(i_in_data.update_value);
            w_div_b = fua_pkg::zext_to_w(i_in_data.weight_value);
        end
    end

    fua_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_zero     (w_div_zero),
        .o_quotient (w_div_q)
    );

    always_comb begin
        if (w_item_weighted) begin
            w_result = r_glob + r_value_sum;
            w_flag   = r_zero_seen;
        end else if (w_item_qfed) begin
            w_result = r_glob - w_div_q;
            w_flag   = r_zero_seen | w_div_zero;
        end else begin
            w_result = r_glob + w_div_q;
            w_flag   = r_zero_seen | w_div_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fua_pkg::MODE_PLAIN;
            r_value_sum  <= '0;
            r_weight_sum <= '0;
            r_count      <= '0;
            r_zero_seen  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.accum) begin
                r_value_sum  <= r_value_sum + (w_item_weighted ? w_div_q : r_upd);
                r_weight_sum <= r_weight_sum + r_wgt;
                if (r_count < fua_pkg::CNT_W'(fua_pkg::MAX_CLIENTS)) begin
                    r_count <= r_count + 1'b1;
                end
                if (w_item_weighted && w_div_zero) begin
                    r_zero_seen <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_value_sum  <= '0;
                r_weight_sum <= '0;
                r_count      <= '0;
                r_zero_seen  <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.load) begin
            r_item_mode <= r_mode;
            r_upd       <= fua_pkg::sext_to_w(i_in_data.update_value);
            r_wgt       <= fua_pkg::zext_to_w(i_in_data.weight_value);
            r_glob      <= fua_pkg::sext_to_w(i_in_data.global_value);
            r_last      <= i_in_data.last_client;
        end
        if (i_cmd.emit) begin
            r_out.aggregated_value <= fua_pkg::w_to_32(w_result);
            r_out.divide_by_zero   <= w_flag;
        end
    end

    assign o_status.cfg_weighted = (r_mode == fua_pkg::MODE_WEIGHTED);
    assign o_status.item_last    = r_last;
    assign o_status.div_done     = w_div_done;
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/fua_ctrl.sv
// Controller state machine of the aggregator.
// Sequences accept, divisions, accumulation and result emission through command signals.
// Depends on fua_pkg.
module fua_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fua_pkg::t_status i_status,
    output fua_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ACCUM     = 6'b000010,
        S_FIN_START = 6'b000100,
        S_DIV_ITEM  = 6'b001000,
        S_DIV_FINAL = 6'b010000,
        S_EMIT      = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.cfg_weighted) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV_ITEM;
                    end else begin
                        n_state = S_ACCUM;
                    end
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.item_last ? S_FIN_START : S_IDLE;
            end
            S_FIN_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_final = 1'b1;
                n_state         = S_DIV_FINAL;
            end
            S_DIV_ITEM: begin
                if (i_status.div_done) begin
                    o_cmd.accum = 1'b1;
                    n_state     = i_status.item_last ? S_EMIT : S_IDLE;
                end
            end
            S_DIV_FINAL: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold the result until the output register is free.
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
